>>> src/slr_pkg.sv
// ============================================================================
// slr_pkg
// Shared types and constants for the slope line rasterizer.
// ============================================================================
`default_nettype none

package slr_pkg;

    // coordinate width of every point and pixel field
    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 32;
    localparam int SLOPE_BITS = COORD_BITS + 1;
    localparam int CNT_W      = $clog2(COORD_BITS);

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    // item kinds carried in s_tuser
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } slr_func_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FIXUP
    } slr_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic div_step;
        logic div_fix;
    } slr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } slr_stat_t;

endpackage : slr_pkg

`default_nettype wire

>>> src/slr_ctrl.sv
// ============================================================================
// slr_ctrl
// Sequencer: accepts items, runs the slope division one quotient bit per
// cycle after a load, and issues commands to the datapath.
// ============================================================================
`default_nettype none

module slr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_tuser,
    input  wire slr_pkg::slr_stat_t stat,
    output slr_pkg::slr_cmd_t      cmd
);
    import slr_pkg::*;

    slr_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    // state and bit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = stat.out_free;
                accept   = s_tvalid && stat.out_free;
                if (accept && (s_tuser == FUNC_LOAD)) begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(COORD_BITS - 1);
                    state_next = ST_DIVIDE;
                end else if (accept) begin
                    cmd.step = 1'b1;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIXUP;
                end
            end
            ST_FIXUP: begin
                cmd.div_fix = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // no item is taken while the division runs
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("item accepted during division");

    // a load always starts a full division
    a_load_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_DIVIDE) && (cnt_reg == CNT_W'(COORD_BITS - 1)))
        else $error("load did not start the division");

    // the fixup follows the last quotient bit
    a_fix_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIXUP) |-> $past(state_reg == ST_DIVIDE) && $past(cnt_reg == '0))
        else $error("fixup without finished division");

endmodule : slr_ctrl

`default_nettype wire

>>> src/slr_datapath.sv
// ============================================================================
// slr_datapath
// Segment registers, restoring divider for the slope, the per-pixel
// stepper and the output register.
// ============================================================================
`default_nettype none

module slr_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire slr_pkg::slr_cmd_t      cmd,
    output slr_pkg::slr_stat_t          stat,
    input  wire logic [slr_pkg::COORD_BITS-1:0] start_x,
    input  wire logic [slr_pkg::COORD_BITS-1:0] start_y,
    input  wire logic [slr_pkg::COORD_BITS-1:0] end_x,
    input  wire logic [slr_pkg::COORD_BITS-1:0] end_y,
    input  wire logic [slr_pkg::COLOR_BITS-1:0] color,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [slr_pkg::COORD_BITS-1:0] pixel_x,
    output logic [slr_pkg::COORD_BITS-1:0] pixel_y,
    output logic [slr_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                        m_tlast
);
    import slr_pkg::*;

    // segment state
    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_BITS-1:0] frac_reg, frac_next;
    logic [SLOPE_BITS-1:0] quot_reg, quot_next;
    logic [COORD_BITS-1:0] srem_reg, srem_next;
    logic [COORD_BITS-1:0] run_reg, run_next;
    logic [COORD_BITS-1:0] limit_reg, limit_next;
    logic                  vert_reg, vert_next;
    logic                  active_reg, active_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;

    // divider state
    logic [COORD_BITS-1:0] div_rem_reg, div_rem_next;
    logic [COORD_BITS-1:0] div_quo_reg, div_quo_next;
    logic                  dy_neg_reg, dy_neg_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic [COLOR_BITS-1:0] out_color_reg, out_color_next;
    logic                  out_last_reg, out_last_next;

    // load helpers
    logic                  swap;
    logic [COORD_BITS-1:0] ax, ay, bx, by;
    logic [COORD_BITS:0]   rem_shift;
    logic [COORD_BITS:0]   frac_sum;
    logic                  frac_carry;
    logic [COORD_BITS-1:0] step_x, step_y;

    // endpoint ordering: x rising, or y rising on a vertical line
    always_comb begin
        swap = (start_x > end_x) || ((start_x == end_x) && (start_y > end_y));
        ax   = swap ? end_x   : start_x;
        ay   = swap ? end_y   : start_y;
        bx   = swap ? start_x : end_x;
        by   = swap ? start_y : end_y;
    end

    // one restoring division step
    assign rem_shift = {div_rem_reg, div_quo_reg[COORD_BITS-1]};

    // fraction accumulate for the non-vertical step
    assign frac_sum   = {1'b0, frac_reg} + {1'b0, srem_reg};
    assign frac_carry = (frac_sum >= {1'b0, run_reg});
    assign step_x     = cursor_x_reg + 1'b1;
    assign step_y     = cursor_y_reg + quot_reg[COORD_BITS-1:0]
                        + {{(COORD_BITS-1){1'b0}}, frac_carry};

    always_comb begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        frac_next      = frac_reg;
        quot_next      = quot_reg;
        srem_next      = srem_reg;
        run_next       = run_reg;
        limit_next     = limit_reg;
        vert_next      = vert_reg;
        active_next    = active_reg;
        color_next     = color_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        dy_neg_next    = dy_neg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        // load: latch segment, prime the divider with |dy| over dx
        if (cmd.load) begin
            color_next    = color;
            cursor_x_next = ax;
            cursor_y_next = ay;
            frac_next     = '0;
            vert_next     = (ax == bx);
            limit_next    = (ax == bx) ? by : bx;
            run_next      = (ax == bx) ? '0 : bx - ax;
            quot_next     = '0;
            srem_next     = '0;
            active_next   = (ax == bx) && (ay < by);
            dy_neg_next   = (ay > by);
            div_quo_next  = (ay > by) ? ay - by : by - ay;
            div_rem_next  = '0;
        end

        // division: one quotient bit per cycle
        if (cmd.div_step) begin
            if (rem_shift >= {1'b0, run_reg}) begin
                div_rem_next = COORD_BITS'(rem_shift - {1'b0, run_reg});
                div_quo_next = {div_quo_reg[COORD_BITS-2:0], 1'b1};
            end else begin
                div_rem_next = rem_shift[COORD_BITS-1:0];
                div_quo_next = {div_quo_reg[COORD_BITS-2:0], 1'b0};
            end
        end

        // latch the slope, with floor correction for a falling line
        if (cmd.div_fix && !vert_reg) begin
            active_next = 1'b1;
            if (!dy_neg_reg) begin
                quot_next = {1'b0, div_quo_reg};
                srem_next = div_rem_reg;
            end else if (div_rem_reg == '0) begin
                quot_next = SLOPE_BITS'(0) - {1'b0, div_quo_reg};
                srem_next = '0;
            end else begin
                quot_next = ~{1'b0, div_quo_reg};
                srem_next = run_reg - div_rem_reg;
            end
        end

        // step: emit the current pixel and advance
        if (cmd.step && active_reg) begin
            out_valid_next = 1'b1;
            out_x_next     = cursor_x_reg;
            out_y_next     = cursor_y_reg;
            out_color_next = color_reg;
            if (vert_reg) begin
                cursor_y_next = cursor_y_reg + 1'b1;
                active_next   = !((cursor_y_next == limit_reg) || (cursor_y_next == '0));
            end else begin
                cursor_x_next = step_x;
                cursor_y_next = step_y;
                frac_next     = frac_carry ? COORD_BITS'(frac_sum - {1'b0, run_reg})
                                           : frac_sum[COORD_BITS-1:0];
                active_next   = !((step_x == limit_reg) || (step_x == '0));
            end
            out_last_next = !active_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            vert_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            vert_reg      <= vert_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cursor_x_reg  <= cursor_x_next;
        cursor_y_reg  <= cursor_y_next;
        frac_reg      <= frac_next;
        quot_reg      <= quot_next;
        srem_reg      <= srem_next;
        run_reg       <= run_next;
        limit_reg     <= limit_next;
        color_reg     <= color_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        dy_neg_reg    <= dy_neg_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign pixel_color   = out_color_reg;
    assign m_tlast       = out_last_reg;

    // accumulated fraction stays below the run on an active sloped line
    a_frac_below_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !vert_reg) |-> (frac_reg < run_reg))
        else $error("fraction accumulator out of range");

    // slope remainder stays below the run on an active sloped line
    a_srem_below_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !vert_reg) |-> (srem_reg < run_reg))
        else $error("slope remainder out of range");

endmodule : slr_datapath

`default_nettype wire

>>> src/slope_line_rasterizer_top.sv
// ============================================================================
// slope_line_rasterizer_top
// Line pixel generator: a load item latches a segment, each step item
// emits the next pixel of it.
//
//   channel | dir | tdata (low bit up)                         | tuser / tlast
//   s_      | in  | start_x, start_y, end_x, end_y, color, pad  | tuser: func
//   m_      | out | pixel_x, pixel_y, pixel_color, pad         | tlast: last
//
// A step item emits one pixel; a pixel stream runs at one pixel per cycle
// while m_tready is high. A load item runs ST_DIVIDE, where the restoring
// divider forms the slope one quotient bit per cycle, and then ST_FIXUP.
// Reset (aresetn low, synchronous) leaves no line loaded and no pixel pending.
// A held result stalls input only while m_tready is low.
// ============================================================================
`default_nettype none

module slope_line_rasterizer_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // start_x, start_y, end_x, end_y, color, zero pad
    input  wire logic [slr_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [slr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);
    import slr_pkg::*;

    slr_cmd_t              cmd;
    slr_stat_t             stat;
    logic [COORD_BITS-1:0] pixel_x, pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;

    slr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    slr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .start_x     (s_tdata[0*COORD_BITS +: COORD_BITS]),
        .start_y     (s_tdata[1*COORD_BITS +: COORD_BITS]),
        .end_x       (s_tdata[2*COORD_BITS +: COORD_BITS]),
        .end_y       (s_tdata[3*COORD_BITS +: COORD_BITS]),
        .color       (s_tdata[4*COORD_BITS +: COLOR_BITS]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .m_tlast     (m_tlast)
    );

    // pack the result payload
    assign m_tdata = M_TDATA_W'({pixel_color, pixel_y, pixel_x});

endmodule : slope_line_rasterizer_top

`default_nettype wire
